FILE: sv/rdd_pkg.sv
// Shared constants, codes and types for the resource deadlock detector.
// No dependencies; used by the core and by its checker.
package rdd_pkg;

	localparam int MAX_PROCS = 8;
	localparam int MAX_RES   = 4;

	localparam int P_CNT_W = $clog2(MAX_PROCS + 1);
	localparam int P_IDX_W = $clog2(MAX_PROCS);
	localparam int R_CNT_W = $clog2(MAX_RES + 1);
	localparam int R_IDX_W = $clog2(MAX_RES);
	localparam int TBL_AW  = P_IDX_W + R_IDX_W;
	localparam int TBL_DEPTH = MAX_PROCS * MAX_RES;

	localparam int OP_W     = 2;
	localparam int PID_W    = 3;
	localparam int RIDX_IN_W = 2;
	localparam int AMT_W    = 8;
	localparam int AVAIL_W  = 12;
	localparam int KIND_W   = 2;
	localparam int PCOUNT_W = 4;
	localparam int RCOUNT_W = 3;
	localparam int CFG_W    = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [AVAIL_W-1:0] AVAIL_MAX = {AVAIL_W{1'b1}};

	localparam logic [OP_W-1:0] OP_LOAD_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_REQ   = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD_AVAIL = 2'd2;
	localparam logic [OP_W-1:0] OP_RUN        = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEADLOCK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUMMARY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'd1;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_CHECK   = 6'b000100,
		ST_RELEASE = 6'b001000,
		ST_DLSCAN  = 6'b010000,
		ST_SUMMARY = 6'b100000
	} state_t;

endpackage

FILE: sv/resource_deadlock_detector_core.sv
// Multi-instance deadlock detector: tables, available vector and run sequencer.
// Depends on rdd_pkg for sizes, operation codes, result kinds and the state type.
//
// Usage. Input requests arrive on in_valid/in_ready with op, proc_index,
// res_index and amount. Load requests (allocation, request, available) are
// taken one per cycle and give no result. A run request starts detection:
// in_ready drops until the run has pushed its last result into the output
// register. Results leave on out_valid/out_ready with kind, process_id,
// deadlock_found and last; a run gives one completed or deadlocked result
// per process in use and then a summary with last set.
// Run sequence: each visit of an unfinished process compares its requests
// with the available vector resource by resource, and a process that fits
// adds its allocation back the same way. Passes over the processes repeat
// while one makes progress, and up to process_count+1 passes can occur;
// then the deadlock report and the summary follow. A single shared compare
// and saturating adder, stepped one resource per cycle, does this work.
// Reset clears the sequencer, the output register and the finish marks and
// sets process_count to 8 and resource_count to 4; the tables hold what was
// last loaded, the available vector what was loaded or added back by a run.
// When the receiver stalls, the sequencer waits with its next result until
// the output register frees.
module resource_deadlock_detector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rdd_pkg::OP_W-1:0]          op,
	input  logic [rdd_pkg::PID_W-1:0]         proc_index,
	input  logic [rdd_pkg::RIDX_IN_W-1:0]     res_index,
	input  logic [rdd_pkg::AMT_W-1:0]         amount,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rdd_pkg::KIND_W-1:0]        kind,
	output logic [rdd_pkg::PID_W-1:0]         process_id,
	output logic                              deadlock_found,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [rdd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rdd_pkg::CFG_W-1:0]         cfg_data
);

	// Configuration registers.
	logic [rdd_pkg::PCOUNT_W-1:0] process_count_q;
	logic [rdd_pkg::RCOUNT_W-1:0] resource_count_q;

	// Table storage; contents are undefined until loaded.
	logic [rdd_pkg::AMT_W-1:0]   alloc_q   [rdd_pkg::TBL_DEPTH];
	logic [rdd_pkg::AMT_W-1:0]   request_q [rdd_pkg::TBL_DEPTH];
	logic [rdd_pkg::AVAIL_W-1:0] avail_q   [rdd_pkg::MAX_RES];

	// Sequencer state.
	rdd_pkg::state_t               state_q;
	logic [rdd_pkg::P_CNT_W-1:0]   p_q;
	logic [rdd_pkg::R_CNT_W-1:0]   r_q;
	logic [rdd_pkg::P_CNT_W-1:0]   np_q;
	logic [rdd_pkg::R_CNT_W-1:0]   nr_q;
	logic [rdd_pkg::MAX_PROCS-1:0] finished_q;
	logic                          progress_q;
	logic                          deadlock_q;

	// Output register.
	logic                          out_valid_q;
	logic [rdd_pkg::KIND_W-1:0]    kind_q;
	logic [rdd_pkg::PID_W-1:0]     pid_q;
	logic                          dl_q;
	logic                          last_q;

	logic                          in_acc;
	logic                          slot_free;
	logic                          emit;
	logic [rdd_pkg::TBL_AW-1:0]    load_addr;
	logic [rdd_pkg::TBL_AW-1:0]    seq_addr;
	logic [rdd_pkg::P_IDX_W-1:0]   p_idx;
	logic [rdd_pkg::R_IDX_W-1:0]   r_idx;
	logic [rdd_pkg::AMT_W-1:0]     req_rd;
	logic [rdd_pkg::AMT_W-1:0]     alloc_rd;
	logic [rdd_pkg::AVAIL_W-1:0]   avail_rd;
	logic [rdd_pkg::AVAIL_W:0]     sum;
	logic [rdd_pkg::AVAIL_W-1:0]   sum_sat;
	logic                          p_end;
	logic                          r_end;
	logic                          avail_we;

	assign in_ready  = (state_q == rdd_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign p_idx     = p_q[rdd_pkg::P_IDX_W-1:0];
	assign r_idx     = r_q[rdd_pkg::R_IDX_W-1:0];
	assign seq_addr  = {p_idx, r_idx};
	assign load_addr = {proc_index[rdd_pkg::P_IDX_W-1:0], res_index[rdd_pkg::R_IDX_W-1:0]};
	assign p_end     = (p_q == np_q);
	assign r_end     = (r_q == nr_q);

	// A result enters the output register when a completion, a deadlock or
	// the summary is ready and the register is free or being drained.
	assign emit = slot_free && (((state_q == rdd_pkg::ST_RELEASE) && r_end)
	            || ((state_q == rdd_pkg::ST_DLSCAN) && !p_end && !finished_q[p_idx])
	            || (state_q == rdd_pkg::ST_SUMMARY));

	// The shared compare and saturating adder work on resource r of process p.
	assign req_rd   = request_q[seq_addr];
	assign alloc_rd = alloc_q[seq_addr];
	assign avail_rd = avail_q[r_idx];
	assign sum      = {1'b0, avail_rd} + {{(rdd_pkg::AVAIL_W + 1 - rdd_pkg::AMT_W){1'b0}}, alloc_rd};
	assign sum_sat  = (sum > {1'b0, rdd_pkg::AVAIL_MAX}) ? rdd_pkg::AVAIL_MAX
	                                                     : sum[rdd_pkg::AVAIL_W-1:0];
	assign avail_we = (state_q == rdd_pkg::ST_RELEASE) && !r_end;

	// Table and available writes; no reset on storage.
	always_ff @(posedge clk) begin
		if (in_acc && op == rdd_pkg::OP_LOAD_ALLOC) begin
			alloc_q[load_addr] <= amount;
		end
		if (in_acc && op == rdd_pkg::OP_LOAD_REQ) begin
			request_q[load_addr] <= amount;
		end
		if (in_acc && op == rdd_pkg::OP_LOAD_AVAIL) begin
			avail_q[res_index[rdd_pkg::R_IDX_W-1:0]] <=
				{{(rdd_pkg::AVAIL_W - rdd_pkg::AMT_W){1'b0}}, amount};
		end else if (avail_we) begin
			avail_q[r_idx] <= sum_sat;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_count_q  <= rdd_pkg::PCOUNT_W'(rdd_pkg::MAX_PROCS);
			resource_count_q <= rdd_pkg::RCOUNT_W'(rdd_pkg::MAX_RES);
		end else if (cfg_we) begin
			case (cfg_index)
				rdd_pkg::REG_PROCESS_COUNT: process_count_q <= cfg_data[rdd_pkg::PCOUNT_W-1:0];
				rdd_pkg::REG_RESOURCE_COUNT: resource_count_q <= cfg_data[rdd_pkg::RCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Run sequencer and output payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdd_pkg::ST_IDLE;
			p_q         <= '0;
			r_q         <= '0;
			np_q        <= '0;
			nr_q        <= '0;
			finished_q  <= '0;
			progress_q  <= 1'b0;
			deadlock_q  <= 1'b0;
			kind_q      <= '0;
			pid_q       <= '0;
			dl_q        <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				rdd_pkg::ST_IDLE: begin
					if (in_acc && op == rdd_pkg::OP_RUN) begin
						// Counts above the maxima act as the maxima.
						np_q <= (process_count_q > rdd_pkg::PCOUNT_W'(rdd_pkg::MAX_PROCS))
						        ? rdd_pkg::P_CNT_W'(rdd_pkg::MAX_PROCS)
						        : rdd_pkg::P_CNT_W'(process_count_q);
						nr_q <= (resource_count_q > rdd_pkg::RCOUNT_W'(rdd_pkg::MAX_RES))
						        ? rdd_pkg::R_CNT_W'(rdd_pkg::MAX_RES)
						        : rdd_pkg::R_CNT_W'(resource_count_q);
						finished_q <= '0;
						progress_q <= 1'b0;
						p_q        <= '0;
						state_q    <= rdd_pkg::ST_SCAN;
					end
				end
				rdd_pkg::ST_SCAN: begin
					if (p_end) begin
						p_q        <= '0;
						progress_q <= 1'b0;
						if (!progress_q) begin
							deadlock_q <= 1'b0;
							state_q    <= rdd_pkg::ST_DLSCAN;
						end
					end else if (finished_q[p_idx]) begin
						p_q <= p_q + rdd_pkg::P_CNT_W'(1);
					end else begin
						r_q     <= '0;
						state_q <= rdd_pkg::ST_CHECK;
					end
				end
				rdd_pkg::ST_CHECK: begin
					if (r_end) begin
						r_q     <= '0;
						state_q <= rdd_pkg::ST_RELEASE;
					end else if ({{(rdd_pkg::AVAIL_W - rdd_pkg::AMT_W){1'b0}}, req_rd}
					             > avail_rd) begin
						p_q     <= p_q + rdd_pkg::P_CNT_W'(1);
						state_q <= rdd_pkg::ST_SCAN;
					end else begin
						r_q <= r_q + rdd_pkg::R_CNT_W'(1);
					end
				end
				rdd_pkg::ST_RELEASE: begin
					if (!r_end) begin
						r_q <= r_q + rdd_pkg::R_CNT_W'(1);
					end else if (slot_free) begin
						finished_q[p_idx] <= 1'b1;
						progress_q  <= 1'b1;
						kind_q      <= rdd_pkg::KIND_DONE;
						pid_q       <= rdd_pkg::PID_W'(p_idx);
						dl_q        <= 1'b0;
						last_q      <= 1'b0;
						p_q         <= p_q + rdd_pkg::P_CNT_W'(1);
						state_q     <= rdd_pkg::ST_SCAN;
					end
				end
				rdd_pkg::ST_DLSCAN: begin
					if (p_end) begin
						state_q <= rdd_pkg::ST_SUMMARY;
					end else if (finished_q[p_idx]) begin
						p_q <= p_q + rdd_pkg::P_CNT_W'(1);
					end else if (slot_free) begin
						deadlock_q  <= 1'b1;
						kind_q      <= rdd_pkg::KIND_DEADLOCK;
						pid_q       <= rdd_pkg::PID_W'(p_idx);
						dl_q        <= 1'b0;
						last_q      <= 1'b0;
						p_q         <= p_q + rdd_pkg::P_CNT_W'(1);
					end
				end
				rdd_pkg::ST_SUMMARY: begin
					if (slot_free) begin
						kind_q      <= rdd_pkg::KIND_SUMMARY;
						pid_q       <= '0;
						dl_q        <= deadlock_q;
						last_q      <= 1'b1;
						state_q     <= rdd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rdd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign process_id     = pid_q;
	assign deadlock_found = dl_q;
	assign last           = last_q;

endmodule

FILE: sv/rdd_checker.sv
// Port-level checker for the resource deadlock detector, bound to the core.
// Depends on rdd_pkg for operation codes and result kinds.
module rdd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [rdd_pkg::OP_W-1:0]          op,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rdd_pkg::KIND_W-1:0]        kind,
	input logic [rdd_pkg::PID_W-1:0]         process_id,
	input logic                              deadlock_found,
	input logic                              last
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(process_id)
		&& $stable(deadlock_found) && $stable(last))
		else $error("stalled result changed");

	// A run request closes the input side at once.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == rdd_pkg::OP_RUN |=> !in_ready)
		else $error("input still open after a run request");

	// Only the summary closes a run, and it reports no process.
	a_last_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == rdd_pkg::KIND_SUMMARY && process_id == '0)
		else $error("last set on a result that is not a clean summary");

	// Per-process results carry no flag and never close the run.
	a_proc_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == rdd_pkg::KIND_DONE || kind == rdd_pkg::KIND_DEADLOCK)
		|-> !deadlock_found && !last)
		else $error("process result carries summary fields");

endmodule

bind resource_deadlock_detector_core rdd_checker u_rdd_checker (.*);
